[hdl/assert_macros.svh]
// Assertion macros shared by the estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ewbe_pkg.sv]
// Package with the types and constants of the EWMA bitrate estimator.
`default_nettype none

package ewbe_pkg;

  // Weight of the newest sample after reset (0.2 in Q0.16).
  localparam logic [15:0] WEIGHT_RESET = 16'd13107;

  // Target bitrate: factor (1600 - Lq) up to the knee, 1120 above it.
  localparam logic [15:0] LAT_KNEE     = 16'd480;
  localparam logic [10:0] TGT_BASE     = 11'd1600;
  localparam logic [10:0] TGT_HIGH     = 11'd1120;
  localparam logic [16:0] TGT_MIN      = 17'd300;
  localparam logic [16:0] TGT_MAX      = 17'd20000;

  // Chunk window in 1/16 ms and chunk limits in bytes.
  localparam logic [16:0] WIN_MIN      = 17'd1600;
  localparam logic [16:0] WIN_MAX      = 17'd32000;
  localparam logic [16:0] CHUNK_MIN    = 17'd1024;
  localparam logic [16:0] CHUNK_MAX    = 17'd65536;

  // Division by 125 through a reciprocal: q0 = (m * DIV_M) >> DIV_SHIFT,
  // off by at most one below for m under 2^23. DIV_SAT caps m so that
  // the quotient lands above every clamp limit, just above the chunk limit.
  localparam logic [6:0]  DIV_D        = 7'd125;
  localparam logic [16:0] DIV_M        = 17'd67108;
  localparam int          DIV_SHIFT    = 23;
  localparam logic [22:0] DIV_SAT      = 23'd8192125;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_BW,
    S_LAT,
    S_LUPD,
    S_TMUL,
    S_TDIV,
    S_TFIX,
    S_CDIV,
    S_CFIX,
    S_EMIT
  } state_t;

  // Operand pair for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_BW,
    MUL_LAT,
    MUL_TGT,
    MUL_CHK,
    MUL_RECIP
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     upd_bw;
    logic     upd_lat;
    logic     div_load;
    logic     div_chunk;
    logic     fix_tgt;
    logic     fix_chk;
    logic     emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

[hdl/ewbe_mul.sv]
// Shared unsigned multiplier with a registered product.
`default_nettype none

module ewbe_mul #(
  parameter int A_W = 28,
  parameter int B_W = 17
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [A_W-1:0]       a,
  input  wire logic [B_W-1:0]       b,
  output logic      [A_W+B_W-1:0]   p
);

  logic [A_W+B_W-1:0] p_r;
  logic [A_W+B_W-1:0] p_nxt;

  // Full-width product of the selected operand pair.
  assign p_nxt = (A_W+B_W)'(a) * (A_W+B_W)'(b);

  // Product register, loaded only on a multiply step.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

[hdl/ewbe_ctrl.sv]
// Sequencing state machine of the EWMA bitrate estimator.
`default_nettype none
`include "assert_macros.svh"

module ewbe_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire ewbe_pkg::sts_t sts,
  output ewbe_pkg::cmd_t      cmd
);

  import ewbe_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: one fixed pass per sample, then wait for the output slot.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_BW;
        end
      end
      S_BW:   state_nxt = S_LAT;
      S_LAT:  state_nxt = S_LUPD;
      S_LUPD: state_nxt = S_TMUL;
      S_TMUL: state_nxt = S_TDIV;
      S_TDIV: state_nxt = S_TFIX;
      S_TFIX: state_nxt = S_CDIV;
      S_CDIV: state_nxt = S_CFIX;
      S_CFIX: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs for each state.
  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = MUL_BW;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      S_BW: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_BW;
      end
      S_LAT: begin
        cmd.upd_bw  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LAT;
      end
      S_LUPD: begin
        cmd.upd_lat = 1'b1;
      end
      S_TMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TGT;
      end
      S_TDIV: begin
        cmd.div_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_RECIP;
      end
      S_TFIX: begin
        cmd.fix_tgt = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CHK;
      end
      S_CDIV: begin
        cmd.div_load  = 1'b1;
        cmd.div_chunk = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_RECIP;
      end
      S_CFIX: begin
        cmd.fix_chk = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = !sts.out_busy;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // An accepted beat always starts the bandwidth step next.
  `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, state_r == S_BW, "accepted beat did not start the update")
  // The latency average is updated right after the bandwidth average.
  `ASSERT_IMPL(a_lat_after_bw, clk, rst_n, cmd.upd_lat, $past(cmd.upd_bw), "latency update out of order")

endmodule

`default_nettype wire

[hdl/ewbe_dp.sv]
// Datapath of the EWMA bitrate estimator: averages, shared multiplier, results.
`default_nettype none
`include "assert_macros.svh"

module ewbe_dp #(
  parameter int EXTRA_FRACTION_BITS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [15:0]    cfg_wr_data,
  input  wire logic [19:0]    in_bw,
  input  wire logic [15:0]    in_lat,
  input  wire ewbe_pkg::cmd_t cmd,
  output ewbe_pkg::sts_t      sts,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [19:0]         out_avg_bw,
  output logic [15:0]         out_avg_lat,
  output logic [14:0]         out_tgt,
  output logic [16:0]         out_chunk
);

  import ewbe_pkg::*;

  localparam int F     = EXTRA_FRACTION_BITS;
  localparam int BW_W  = 20 + F;
  localparam int LAT_W = 16 + F;
  localparam int AW    = (BW_W > DIV_SHIFT) ? BW_W : DIV_SHIFT;
  localparam int MB_W  = 17;
  localparam int PW    = AW + MB_W;

  // Control state.
  logic [15:0]      weight_r;
  logic [BW_W-1:0]  acc_bw_r;
  logic [LAT_W-1:0] acc_lat_r;
  logic             out_valid_r;

  // Payload registers.
  logic [19:0]      bw_in_r;
  logic [15:0]      lat_in_r;
  logic             neg_r;
  logic [22:0]      m_r;
  logic [14:0]      tgt_r;
  logic [16:0]      chunk_r;
  logic [19:0]      out_bw_r;
  logic [15:0]      out_lat_r;
  logic [14:0]      out_tgt_r;
  logic [16:0]      out_chunk_r;

  logic [BW_W-1:0]  fresh_bw, bw_mag;
  logic [LAT_W-1:0] fresh_lat, lat_mag;
  logic             bw_neg, lat_neg, mul_neg;
  logic [15:0]      lq;
  logic [10:0]      tgt_factor;
  logic [16:0]      lq2, win;
  logic [PW-1:0]    p, p_hi, p_ceil, m_raw;
  logic [22:0]      m_sat;
  logic [AW-1:0]    mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [BW_W-1:0]  acc_bw_nxt;
  logic [LAT_W-1:0] acc_lat_nxt;
  logic [16:0]      q0, q;
  logic [24:0]      q_ext, q125, rem;
  logic [14:0]      tgt_nxt;
  logic [16:0]      chunk_nxt;

  // Difference between the new sample and the average, as sign and magnitude.
  assign fresh_bw  = {bw_in_r, {F{1'b0}}};
  assign fresh_lat = {lat_in_r, {F{1'b0}}};
  assign bw_neg    = acc_bw_r > fresh_bw;
  assign lat_neg   = acc_lat_r > fresh_lat;
  assign bw_mag    = bw_neg ? (acc_bw_r - fresh_bw) : (fresh_bw - acc_bw_r);
  assign lat_mag   = lat_neg ? (acc_lat_r - fresh_lat) : (fresh_lat - acc_lat_r);

  // Latency output and the two factors derived from it.
  assign lq         = acc_lat_r[LAT_W-1:F];
  assign tgt_factor = (lq <= LAT_KNEE) ? (TGT_BASE - lq[10:0]) : TGT_HIGH;
  assign lq2        = {lq, 1'b0};
  assign win        = (lq2 < WIN_MIN) ? WIN_MIN : ((lq2 > WIN_MAX) ? WIN_MAX : lq2);

  // Dividend for the divide-by-125 step, capped so it stays under 2^23.
  assign m_raw = cmd.div_chunk ? (p >> (F + 10)) : (p >> (F + 4));
  assign m_sat = (m_raw >= PW'(DIV_SAT)) ? DIV_SAT : m_raw[22:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd.mul_sel)
      MUL_BW: begin
        mul_a   = AW'(bw_mag);
        mul_b   = MB_W'(weight_r);
        mul_neg = bw_neg;
      end
      MUL_LAT: begin
        mul_a   = AW'(lat_mag);
        mul_b   = MB_W'(weight_r);
        mul_neg = lat_neg;
      end
      MUL_TGT: begin
        mul_a = AW'(acc_bw_r);
        mul_b = MB_W'(tgt_factor);
      end
      MUL_CHK: begin
        mul_a = AW'(acc_bw_r);
        mul_b = win;
      end
      MUL_RECIP: begin
        mul_a = AW'(m_sat);
        mul_b = DIV_M;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  ewbe_mul #(
    .A_W (AW),
    .B_W (MB_W)
  ) u_mul (
    .clk (clk),
    .en  (cmd.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  // Average update: add the floor of w*d/2^16, or subtract its ceiling when d < 0.
  assign p_hi        = p >> 16;
  assign p_ceil      = (p + PW'(16'hFFFF)) >> 16;
  assign acc_bw_nxt  = neg_r ? (acc_bw_r - p_ceil[BW_W-1:0]) : (acc_bw_r + p_hi[BW_W-1:0]);
  assign acc_lat_nxt = neg_r ? (acc_lat_r - p_ceil[LAT_W-1:0])
                             : (acc_lat_r + p_hi[LAT_W-1:0]);

  // Reciprocal quotient and its one-step correction.
  assign q0    = p[DIV_SHIFT +: 17];
  assign q_ext = 25'(q0);
  assign q125  = (q_ext << 7) - (q_ext << 2) + q_ext;
  assign rem   = 25'(m_r) - q125;
  assign q     = q0 + 17'(rem >= 25'(DIV_D));

  // Clamp of the two results.
  always_comb begin
    if (q < TGT_MIN) begin
      tgt_nxt = TGT_MIN[14:0];
    end else if (q > TGT_MAX) begin
      tgt_nxt = TGT_MAX[14:0];
    end else begin
      tgt_nxt = q[14:0];
    end
    if (q < CHUNK_MIN) begin
      chunk_nxt = CHUNK_MIN;
    end else if (q > CHUNK_MAX) begin
      chunk_nxt = CHUNK_MAX;
    end else begin
      chunk_nxt = q;
    end
  end

  // Weight, averages and output beat flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r    <= WEIGHT_RESET;
      acc_bw_r    <= '0;
      acc_lat_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        weight_r <= cfg_wr_data;
      end
      if (cmd.upd_bw) begin
        acc_bw_r <= acc_bw_nxt;
      end
      if (cmd.upd_lat) begin
        acc_lat_r <= acc_lat_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample, intermediate and output payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bw_in_r  <= in_bw;
      lat_in_r <= in_lat;
    end
    if (cmd.mul_en) begin
      neg_r <= mul_neg;
    end
    if (cmd.div_load) begin
      m_r <= m_sat;
    end
    if (cmd.fix_tgt) begin
      tgt_r <= tgt_nxt;
    end
    if (cmd.fix_chk) begin
      chunk_r <= chunk_nxt;
    end
    if (cmd.emit) begin
      out_bw_r    <= acc_bw_r[BW_W-1:F];
      out_lat_r   <= lq;
      out_tgt_r   <= tgt_r;
      out_chunk_r <= chunk_r;
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_avg_bw   = out_bw_r;
  assign out_avg_lat  = out_lat_r;
  assign out_tgt      = out_tgt_r;
  assign out_chunk    = out_chunk_r;

  // A result load always presents a beat on the next cycle.
  `ASSERT_NEXT(a_emit_valid, clk, rst_n, cmd.emit, out_valid_r, "result load lost")
  // Presented target bitrates lie within their clamp range, chunk sizes at or above their lower limit.
  `ASSERT_IMPL(a_out_range, clk, rst_n, out_valid_r, (17'(out_tgt_r) >= TGT_MIN) && (17'(out_tgt_r) <= TGT_MAX) && (out_chunk_r >= CHUNK_MIN), "result outside its clamp range")

endmodule

`default_nettype wire

[hdl/ewma_bitrate_estimator_top.sv]
// EWMA bitrate estimator: smooths bandwidth and latency samples and derives
// a target bitrate and a chunk size for each one.
//
// Input beat (in_*): bandwidth in kbps and latency in ms Q12.4. One result beat
// (out_*) follows each input beat: both averages, the target bitrate and the
// chunk size. The weight of the newest sample is written on cfg_wr_en.
//
// Timing: one multiplier is shared by six products per sample (two average
// updates, two result products and two divides by 125 through a reciprocal).
// out_tvalid rises in the same cycle in which in_tready returns. in_tready is
// high only while the block is idle, so a new sample is not taken until the
// last one is finished and its result is loaded into the output register.
//
// Output: the result sits in its own register; a new sample is taken while an
// earlier result still waits. If the receiver stalls, the block holds the
// next finished result until the output register is free.
//
// Reset (rst_n low at a clock edge) clears both averages to zero and sets the
// weight to 0.2; no output beat is pending afterwards.
`default_nettype none

module ewma_bitrate_estimator_top #(
  parameter int EXTRA_FRACTION_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // bandwidth_kbps[19:0], latency_ms_q4[35:20], pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // avg_bandwidth_kbps[19:0], avg_latency_ms_q4[35:20],
                                       // target_bitrate_kbps[50:36], chunk_bytes[67:51], pad
);

  import ewbe_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [19:0] out_avg_bw;
  logic [15:0] out_avg_lat;
  logic [14:0] out_tgt;
  logic [16:0] out_chunk;

  // Sequencer.
  ewbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  ewbe_dp #(
    .EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bw       (in_tdata[19:0]),
    .in_lat      (in_tdata[35:20]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_avg_bw  (out_avg_bw),
    .out_avg_lat (out_avg_lat),
    .out_tgt     (out_tgt),
    .out_chunk   (out_chunk)
  );

  // Result beat packing, first field in the lowest bits.
  assign out_tdata = {4'b0, out_chunk, out_tgt, out_avg_lat, out_avg_bw};

endmodule

`default_nettype wire

[dv/ewma_bitrate_estimator_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts every estimator result beat and compares it with the output channel.
module ewma_bitrate_estimator_checker #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,    // bandwidth_kbps[19:0], latency_ms_q4[35:20], pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,   // avg_bandwidth_kbps[19:0], avg_latency_ms_q4[35:20],
                                   // target_bitrate_kbps[50:36], chunk_bytes[67:51], pad
  output int          mismatches,
  output int          outstanding,
  output int          results_checked
);

  localparam logic [15:0] RESET_WEIGHT = 16'd13107;
  localparam logic [63:0] WEIGHT_ONE   = 64'd65536;
  localparam logic [63:0] LAT_KNEE_Q4  = 64'd480;
  localparam logic [63:0] TARGET_MIN   = 64'd300;
  localparam logic [63:0] TARGET_MAX   = 64'd20000;
  localparam logic [63:0] WINDOW_MIN   = 64'd1600;
  localparam logic [63:0] WINDOW_MAX   = 64'd32000;
  localparam logic [63:0] CHUNK_MIN    = 64'd1024;
  localparam logic [63:0] CHUNK_MAX    = 64'd65536;
  localparam int          REPORT_LIMIT = 10;

  // One result beat, laid out exactly as the low 68 bits of out_tdata.
  typedef struct packed {
    logic [16:0] chunk_bytes;
    logic [14:0] target_kbps;
    logic [15:0] avg_lat_q4;
    logic [19:0] avg_bw_kbps;
  } estimate_t;

  logic [15:0] weight;
  logic [63:0] bw_avg_acc;
  logic [63:0] lat_avg_acc;
  estimate_t   estimate_q[$];
  int          bad_count;
  int          checked_count;

  // Moving average step: the new sample gets weight w, the old average the rest.
  function automatic logic [63:0] ewma_update(input logic [63:0] acc,
                                              input logic [63:0] sample,
                                              input logic [15:0] w);
    logic [63:0] w_new;
    logic [63:0] w_old;
    w_new = {48'd0, w};
    w_old = WEIGHT_ONE - w_new;
    return (w_new * (sample << FRAC_BITS) + w_old * acc) >> 16;
  endfunction

  function automatic logic [63:0] clamp64(input logic [63:0] v,
                                          input logic [63:0] lo,
                                          input logic [63:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Target bitrate and chunk size derived from the freshly updated averages.
  function automatic estimate_t derive_estimate(input logic [63:0] bw_acc,
                                                input logic [63:0] lat_acc);
    logic [63:0] lat_q4;
    logic [63:0] target;
    logic [63:0] window;
    logic [63:0] chunk;
    estimate_t   est;
    lat_q4 = (lat_acc >> FRAC_BITS) & 64'hFFFF;
    if (lat_q4 <= LAT_KNEE_Q4) begin
      target = ((bw_acc * (64'd1600 - lat_q4)) >> FRAC_BITS) / 64'd2000;
    end else begin
      target = ((bw_acc * 64'd56) >> FRAC_BITS) / 64'd100;
    end
    target = clamp64(target, TARGET_MIN, TARGET_MAX);
    window = clamp64(lat_q4 << 1, WINDOW_MIN, WINDOW_MAX);
    chunk  = clamp64(((bw_acc * window) >> (FRAC_BITS + 4)) / 64'd8000, CHUNK_MIN, CHUNK_MAX);
    est.avg_bw_kbps = bw_acc[FRAC_BITS +: 20];
    est.avg_lat_q4  = lat_q4[15:0];
    est.target_kbps = target[14:0];
    est.chunk_bytes = chunk[16:0];
    return est;
  endfunction

  // Track weight writes and accepted samples, then check each result beat in order.
  always @(posedge clk) begin
    estimate_t got;
    estimate_t want;
    if (!rst_n) begin
      weight      = RESET_WEIGHT;
      bw_avg_acc  = 64'd0;
      lat_avg_acc = 64'd0;
      estimate_q.delete();
    end else begin
      if (cfg_wr_en) begin
        weight = cfg_wr_data;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[67:0];
        if (estimate_q.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT) begin
            $display("%t: result beat with nothing expected: bw %0d lat %0d tgt %0d chunk %0d",
                     $realtime, got.avg_bw_kbps, got.avg_lat_q4, got.target_kbps,
                     got.chunk_bytes);
          end
        end else begin
          want = estimate_q.pop_front();
          checked_count++;
          if (got !== want) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT) begin
              $display("%t: result %0d differs (expected / actual)", $realtime, checked_count);
              $display("  avg_bandwidth_kbps  %0d / %0d", want.avg_bw_kbps, got.avg_bw_kbps);
              $display("  avg_latency_ms_q4   %0d / %0d", want.avg_lat_q4, got.avg_lat_q4);
              $display("  target_bitrate_kbps %0d / %0d", want.target_kbps, got.target_kbps);
              $display("  chunk_bytes         %0d / %0d", want.chunk_bytes, got.chunk_bytes);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        bw_avg_acc  = ewma_update(bw_avg_acc, {44'd0, in_tdata[19:0]}, weight);
        lat_avg_acc = ewma_update(lat_avg_acc, {48'd0, in_tdata[35:20]}, weight);
        estimate_q  = {estimate_q, derive_estimate(bw_avg_acc, lat_avg_acc)};
      end
    end
    outstanding     <= estimate_q.size();
    mismatches      <= bad_count;
    results_checked <= checked_count;
  end

endmodule

[dv/tb_ewma_bitrate_estimator_top.sv]
`timescale 1ns / 1ps
// Testbench top: drives samples and weight writes into the estimator and reports the verdict.
module tb_ewma_bitrate_estimator_top;

  localparam int FRAC_BITS        = 8;
  localparam int STALL_LIMIT      = 3000;
  localparam int DRAIN_CYCLES     = 12;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES    = 6;
  localparam int PHASE_SAMPLES    = 258;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_tvalid   = 1'b0;
  logic [39:0] in_tdata    = 40'd0;
  logic        out_tready  = 1'b0;
  wire logic        in_tready;
  wire logic        out_tvalid;
  wire logic [71:0] out_tdata;

  int   mismatches;
  int   outstanding;
  int   results_checked;
  int   send_idle_pct   = 0;
  int   recv_idle_pct   = 0;
  logic want_long_hold  = 1'b0;
  logic long_hold_done  = 1'b0;
  int   hold_count      = 0;
  int   quiet_cycles    = 0;
  int   samples_sent    = 0;
  int   weight_settings = 0;

  ewma_bitrate_estimator_top #(
    .EXTRA_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ewma_bitrate_estimator_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .results_checked(results_checked)
  );

  always #6 clk = ~clk;

  // Receiver: random back-pressure, plus one long hold-off while the sender keeps going.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (want_long_hold && !long_hold_done) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count == LONG_HOLD_CYCLES) begin
        long_hold_done <= 1'b1;
      end
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one sample beat, with random idle cycles in front of it.
  task automatic send_sample(input logic [19:0] bw, input logic [15:0] lat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, lat, bw};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Random sample biased toward the knee and the unclamped target and chunk ranges.
  task automatic send_random_sample();
    logic [19:0] bw;
    logic [15:0] lat;
    case ($urandom_range(0, 3))
      0: bw = 20'($urandom_range(0, 20'hFFFFF));
      1: bw = 20'($urandom_range(0, 30000));
      2: bw = 20'($urandom_range(30000, 800000));
      default: bw = 20'($urandom_range(0, 6000));
    endcase
    case ($urandom_range(0, 3))
      0: lat = 16'($urandom_range(0, 16'hFFFF));
      1: lat = 16'($urandom_range(0, 1200));
      2: lat = 16'($urandom_range(400, 600));
      default: lat = 16'($urandom_range(700, 17000));
    endcase
    send_sample(bw, lat);
  endtask

  // Wait until every expected result has arrived and the block has gone quiet.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_weight(input logic [15:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    weight_settings++;
  endtask

  // Stimulus: directed corners first, then random phases under several weights.
  initial begin
    logic [15:0] w;
    repeat (8) @(posedge clk);
    rst_n         <= 1'b1;
    send_idle_pct <= 36;
    recv_idle_pct <= 80;
    @(posedge clk);

    // Zero averages after reset saturate to the lower limits.
    send_sample(20'd0, 16'd0);
    send_sample(20'd1000, 16'd320);

    // Full-scale weight: averages follow the sample; walk the field extremes and knee.
    wait_drained();
    write_weight(16'hFFFF);
    send_sample(20'hFFFFF, 16'd0);
    send_sample(20'hFFFFF, 16'hFFFF);
    send_sample(20'd0, 16'hFFFF);
    send_sample(20'd20000, 16'd480);
    send_sample(20'd20000, 16'd480);
    send_sample(20'd20000, 16'd481);
    send_sample(20'd20000, 16'd482);
    send_sample(20'd25000, 16'd800);
    send_sample(20'd100000, 16'd801);
    send_sample(20'd300000, 16'd16000);
    send_sample(20'd300000, 16'd16001);
    send_sample(20'd1, 16'd16);
    send_sample(20'd375, 16'd0);
    send_sample(20'h55555, 16'hAAAA);
    send_sample(20'hAAAAA, 16'h5555);

    // Zero weight: the averages must hold their values.
    wait_drained();
    write_weight(16'd0);
    send_sample(20'hFFFFF, 16'hFFFF);
    send_sample(20'd0, 16'd0);

    // Smallest nonzero weight.
    wait_drained();
    write_weight(16'd1);
    send_sample(20'hFFFFF, 16'hFFFF);
    send_sample(20'd12345, 16'd100);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p / 2)
        0: begin
          send_idle_pct <= 36;
          recv_idle_pct <= 80;
        end
        1: begin
          send_idle_pct <= 80;
          recv_idle_pct <= 36;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      case (p)
        0: w = 16'd40000;
        2: w = 16'hFFFF;
        3: w = 16'd2000;
        5: w = 16'd13107;
        default: w = 16'($urandom_range(0, 16'hFFFF));
      endcase
      if (p == 4) begin
        want_long_hold <= 1'b1;
      end
      write_weight(w);
      repeat (PHASE_SAMPLES) send_random_sample();
    end

    wait_drained();
    $display("Sent %0d samples under %0d weight settings; %0d result beats checked.",
             samples_sent, weight_settings, results_checked);
    $display("Covered sender-heavy, receiver-heavy and no idling, plus one long output hold-off.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
